@@ hdl/ihex_pkg.sv @@
// Shared types, codes and helpers for the Intel HEX record encoder.
`timescale 1ns / 1ps
package ihex_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DATA,
    ST_XFER,
    ST_EOF
  } ihex_state_t;

  typedef enum logic [1:0] {
    CFG_BASE_ADDRESS     = 2'd0,
    CFG_TRANSFER_ADDRESS = 2'd1,
    CFG_TRANSFER_ENABLE  = 2'd2
  } ihex_cfg_index_t;

  localparam logic       MODE_DATA    = 1'b0;
  localparam logic       MODE_END     = 1'b1;
  localparam logic [7:0] REC_TYPE_DATA = 8'h00;
  localparam logic [7:0] REC_TYPE_EOF  = 8'h01;
  localparam logic [7:0] REC_TYPE_XFER = 8'h03;
  localparam logic [6:0] CHAR_COLON    = 7'h3A;
  localparam logic [6:0] CHAR_NEWLINE  = 7'h0A;

  // Upper-case hex digit for one nibble.
  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] c;
    if (nib < 4'd10) begin
      c = 7'h30 + {3'b000, nib};
    end else begin
      c = 7'h37 + {3'b000, nib};
    end
    return c;
  endfunction

endpackage

@@ hdl/ihex_if.sv @@
// Valid/ready channel interfaces for input items and output character pairs.
`timescale 1ns / 1ps
interface ihex_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface ihex_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] first_char;
  logic [6:0] second_char;
  logic       last_of_run;

  modport source (output valid, output first_char, output second_char,
                  output last_of_run, input ready);
  modport sink   (input valid, input first_char, input second_char,
                  input last_of_run, output ready);
endinterface

@@ hdl/intel_hex_record_encoder.sv @@
// Intel HEX record encoder: gathers bytes into records and emits ASCII pairs.
// A data byte that does not complete a record is stored and leaves the input
// ready. The byte that completes a record starts a sequencer that walks the
// record one byte per cycle, unless the output is stalled, through a shared
// checksum adder and hex formatter, giving one character pair per cycle into
// the output register: RECORD_BYTES+6 pairs. An end item flushes any partial
// record (zero-padded, count field still RECORD_BYTES), then the optional
// type-03 record (6 pairs) and the end-of-file record (6 pairs). The input is
// not ready while a record is being emitted. A write to base_address also
// reloads the running address.
`timescale 1ns / 1ps
module intel_hex_record_encoder #(
  parameter int RECORD_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  ihex_in_if.sink     items,
  ihex_out_if.source  pairs
);
  import ihex_pkg::*;

  localparam int CNT_W = $clog2(RECORD_BYTES + 1);
  localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam int POS_W = $clog2(RECORD_BYTES + 6);
  localparam logic [POS_W-1:0] DATA_CKS  = POS_W'(RECORD_BYTES + 4);
  localparam logic [POS_W-1:0] DATA_LAST = POS_W'(RECORD_BYTES + 5);
  localparam logic [POS_W-1:0] SHORT_CKS  = POS_W'(4);
  localparam logic [POS_W-1:0] SHORT_LAST = POS_W'(5);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(RECORD_BYTES);
  localparam logic [7:0]       COUNT_FIELD = 8'(RECORD_BYTES);

  logic [7:0]       record_buffer [RECORD_BYTES];
  logic [CNT_W-1:0] byte_count;
  logic [15:0]      current_address;
  logic [15:0]      transfer_address;
  logic             transfer_enable;

  ihex_state_t      state, state_next;
  logic [POS_W-1:0] pos;
  logic [7:0]       sum;
  logic [3:0]       lo_prev;
  logic             end_run;

  logic             out_valid;
  logic [6:0]       first_char, second_char;
  logic             last_of_run;

  logic             in_fire;
  logic             emit;
  logic [POS_W-1:0] cks_pos, last_pos;
  logic             at_last;
  logic [POS_W-1:0] data_pos;
  logic [7:0]       data_val;
  logic [7:0]       fld;
  logic [6:0]       pair_first, pair_second;
  logic             pair_last;

  assign items.ready        = (state == ST_IDLE);
  assign in_fire            = items.valid && items.ready;
  assign emit               = (state != ST_IDLE) && (!out_valid || pairs.ready);
  assign pairs.valid        = out_valid;
  assign pairs.first_char   = first_char;
  assign pairs.second_char  = second_char;
  assign pairs.last_of_run  = last_of_run;

  // Field byte at the current position of the record being emitted.
  always_comb begin
    cks_pos  = (state == ST_DATA) ? DATA_CKS : SHORT_CKS;
    last_pos = (state == ST_DATA) ? DATA_LAST : SHORT_LAST;
    at_last  = (pos == last_pos);
    data_pos = pos - POS_W'(4);
    // Bytes beyond the held count read as zero padding.
    if ((CNT_W + POS_W)'(data_pos) < (CNT_W + POS_W)'(byte_count)) begin
      data_val = record_buffer[data_pos[IDX_W-1:0]];
    end else begin
      data_val = 8'h00;
    end
    fld = 8'h00;
    case (state)
      ST_DATA: begin
        if (pos == POS_W'(0)) fld = COUNT_FIELD;
        else if (pos == POS_W'(1)) fld = current_address[15:8];
        else if (pos == POS_W'(2)) fld = current_address[7:0];
        else if (pos == POS_W'(3)) fld = REC_TYPE_DATA;
        else if (pos < cks_pos) fld = data_val;
        else fld = 8'h00 - sum;
      end
      ST_XFER: begin
        if (pos == POS_W'(0)) fld = 8'h00;
        else if (pos == POS_W'(1)) fld = transfer_address[15:8];
        else if (pos == POS_W'(2)) fld = transfer_address[7:0];
        else if (pos == POS_W'(3)) fld = REC_TYPE_XFER;
        else fld = 8'h00 - sum;
      end
      ST_EOF: begin
        if (pos == POS_W'(3)) fld = REC_TYPE_EOF;
        else if (pos < cks_pos) fld = 8'h00;
        else fld = 8'h00 - sum;
      end
      default: fld = 8'h00;
    endcase
    // A pair straddles bytes: low nibble of the previous byte, high of this.
    pair_first  = (pos == POS_W'(0)) ? CHAR_COLON : hex_char(lo_prev);
    pair_second = at_last ? CHAR_NEWLINE : hex_char(fld[7:4]);
    pair_last   = at_last && ((state == ST_EOF) || ((state == ST_DATA) && !end_run));
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (items.mode == MODE_DATA) begin
            if (byte_count + CNT_W'(1) >= FULL_CNT) state_next = ST_DATA;
          end else if (byte_count != '0) begin
            state_next = ST_DATA;
          end else begin
            state_next = transfer_enable ? ST_XFER : ST_EOF;
          end
        end
      end
      ST_DATA: begin
        if (emit && at_last) begin
          if (!end_run) state_next = ST_IDLE;
          else state_next = transfer_enable ? ST_XFER : ST_EOF;
        end
      end
      ST_XFER: if (emit && at_last) state_next = ST_EOF;
      ST_EOF:  if (emit && at_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      pos              <= '0;
      sum              <= 8'h00;
      lo_prev          <= 4'h0;
      end_run          <= 1'b0;
      byte_count       <= '0;
      current_address  <= 16'h0000;
      transfer_address <= 16'h0000;
      transfer_enable  <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_ADDRESS:     current_address  <= cfg_data;
          CFG_TRANSFER_ADDRESS: transfer_address <= cfg_data;
          CFG_TRANSFER_ENABLE:  transfer_enable  <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_fire) begin
        end_run <= (items.mode == MODE_END);
        if (items.mode == MODE_DATA) byte_count <= byte_count + CNT_W'(1);
      end
      if (emit) begin
        out_valid <= 1'b1;
        lo_prev   <= fld[3:0];
        if (at_last) begin
          pos <= '0;
          sum <= 8'h00;
          if (state == ST_DATA) begin
            current_address <= current_address + 16'(byte_count);
            byte_count      <= '0;
          end
        end else begin
          pos <= pos + POS_W'(1);
          sum <= sum + fld;
        end
      end else if (pairs.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (items.mode == MODE_DATA)) begin
      record_buffer[byte_count[IDX_W-1:0]] <= items.data_byte;
    end
    if (emit) begin
      first_char  <= pair_first;
      second_char <= pair_second;
      last_of_run <= pair_last;
    end
  end

endmodule

@@ hdl/ihex_checker.sv @@
// Port-level assertions for the Intel HEX record encoder, bound to the top level.
`timescale 1ns / 1ps
module ihex_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_mode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] first_char,
  input logic [6:0] second_char,
  input logic       last_of_run
);
  import ihex_pkg::*;

  // A pair offered but not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output pair dropped while stalled");

  // A stalled pair keeps its characters.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(first_char) && $stable(second_char)
      && $stable(last_of_run))
    else $error("output pair changed while stalled");

  // In the middle of a run no new item may enter.
  a_busy_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> !in_ready)
    else $error("input ready in the middle of a run");

  // An end item always causes records, so the block is busy next cycle.
  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_mode == MODE_END) |=> !in_ready)
    else $error("end item caused no output");

endmodule

bind intel_hex_record_encoder ihex_checker u_ihex_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (items.valid),
  .in_ready    (items.ready),
  .in_mode     (items.mode),
  .out_valid   (pairs.valid),
  .out_ready   (pairs.ready),
  .first_char  (pairs.first_char),
  .second_char (pairs.second_char),
  .last_of_run (pairs.last_of_run)
);
